>>> rtl/core/acn_pkg.sv
// ----------------------------------------------------------------------------
// acn_pkg: shared types, widths and step functions for the contrast normalizer
// Holds the data widths, the per-stage payload structs of the two root
// pipelines and the divider pipeline, and their one-step functions.
// ----------------------------------------------------------------------------
package acn_pkg;

    // Field widths
    localparam int PIXEL_BITS = 10;
    localparam int MEAN_W     = 16;
    localparam int ENERGY_W   = 42;
    localparam int GAIN_W     = 15;
    localparam int OUT_W      = 16;

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(22938);   // 1.4 in Q1.14

    // Deviation magnitude, Q.6
    localparam int P6_W  = PIXEL_BITS + 6;
    localparam int MAG_W = (P6_W > MEAN_W) ? P6_W : MEAN_W;

    // First root: sqrt(E * 65536)
    localparam int X1_W  = ENERGY_W + 16;
    localparam int R1_W  = X1_W / 2;
    localparam int RM1_W = R1_W + 2;

    // Second root: sqrt of the first root, result is r in Q.4
    localparam int R2_W  = (R1_W + 1) / 2;
    localparam int X2_W  = 2 * R2_W;
    localparam int RM2_W = R2_W + 2;

    // Divider: q = gain*mag / (4*r4 + mag), q < gain
    localparam int R6_W  = R2_W + 2;
    localparam int DEN_W = ((R6_W > MAG_W) ? R6_W : MAG_W) + 1;
    localparam int NUM_W = GAIN_W + MAG_W;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [X1_W-1:0]  rad;
        logic [RM1_W-1:0] rem;
        logic [R1_W-1:0]  root;
    } t_sq1;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [X2_W-1:0]  rad;
        logic [RM2_W-1:0] rem;
        logic [R2_W-1:0]  root;
    } t_sq2;

    typedef struct packed {
        logic              neg;
        logic [GAIN_W-1:0] num_lo;
        logic [DEN_W-1:0]  den;
        logic [DEN_W-1:0]  rem;
        logic [GAIN_W-1:0] quo;
    } t_div;

    // one result bit of the first square root
    function automatic t_sq1 sq1_step(input t_sq1 s);
        logic [RM1_W+1:0] t;
        logic [RM1_W+1:0] trial;
        t_sq1             o;
        o     = s;
        t     = {s.rem, s.rad[X1_W-1 -: 2]};
        trial = (RM1_W+2)'({s.root, 2'b01});
        if (t >= trial) begin
            o.rem  = RM1_W'(t - trial);
            o.root = {s.root[R1_W-2:0], 1'b1};
        end else begin
            o.rem  = t[RM1_W-1:0];
            o.root = {s.root[R1_W-2:0], 1'b0};
        end
        o.rad = {s.rad[X1_W-3:0], 2'b00};
        return o;
    endfunction

    // one result bit of the second square root
    function automatic t_sq2 sq2_step(input t_sq2 s);
        logic [RM2_W+1:0] t;
        logic [RM2_W+1:0] trial;
        t_sq2             o;
        o     = s;
        t     = {s.rem, s.rad[X2_W-1 -: 2]};
        trial = (RM2_W+2)'({s.root, 2'b01});
        if (t >= trial) begin
            o.rem  = RM2_W'(t - trial);
            o.root = {s.root[R2_W-2:0], 1'b1};
        end else begin
            o.rem  = t[RM2_W-1:0];
            o.root = {s.root[R2_W-2:0], 1'b0};
        end
        o.rad = {s.rad[X2_W-3:0], 2'b00};
        return o;
    endfunction

    // one quotient bit of the restoring divider
    function automatic t_div div_step(input t_div s);
        logic [DEN_W:0] t;
        logic [DEN_W:0] d;
        t_div           o;
        o = s;
        t = {s.rem, s.num_lo[GAIN_W-1]};
        d = {1'b0, s.den};
        if (t >= d) begin
            o.rem = DEN_W'(t - d);
            o.quo = {s.quo[GAIN_W-2:0], 1'b1};
        end else begin
            o.rem = t[DEN_W-1:0];
            o.quo = {s.quo[GAIN_W-2:0], 1'b0};
        end
        o.num_lo = {s.num_lo[GAIN_W-2:0], 1'b0};
        return o;
    endfunction

endpackage

>>> rtl/core/acn_out_queue.sv
// ----------------------------------------------------------------------------
// acn_out_queue: output register with one skid entry
// Decouples the pipeline from the downstream stall; o_full is registered and
// freezes the pipeline for as long as the skid entry is occupied.
// ----------------------------------------------------------------------------
module acn_out_queue import acn_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [OUT_W-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [OUT_W-1:0] o_data
);

    logic             r_out_v;
    logic             n_out_v;
    logic [OUT_W-1:0] r_out;
    logic [OUT_W-1:0] n_out;
    logic             r_skid_v;
    logic             n_skid_v;
    logic [OUT_W-1:0] r_skid;
    logic [OUT_W-1:0] n_skid;
    logic             out_free;

    assign out_free = !r_out_v || !i_stall;

    always_comb begin
        n_out_v  = r_out_v;
        n_out    = r_out;
        n_skid_v = r_skid_v;
        n_skid   = r_skid;
        if (out_free) begin
            if (r_skid_v) begin
                n_out_v  = 1'b1;
                n_out    = r_skid;
                n_skid_v = 1'b0;
            end else begin
                n_out_v = i_push;
                n_out   = i_data;
            end
        end else if (i_push) begin
            n_skid_v = 1'b1;
            n_skid   = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full  = r_skid_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    // skid only fills behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry valid while output register empty");

    // pipeline must be frozen while the skid entry is occupied
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> !i_push)
        else $error("push into full output queue");

    // a push against a held output lands in the skid entry
    a_push_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && i_stall && !r_skid_v && i_push)
        |=> (r_skid_v && r_skid == $past(i_data)))
        else $error("pushed result lost while output stalled");

endmodule

>>> rtl/core/adaptive_contrast_normalizer_unit.sv
// ----------------------------------------------------------------------------
// adaptive_contrast_normalizer_unit: soft-saturating local contrast normalizer
// Per pixel: d = pixel*64 - mean, r = 4th root of the side energy (min 1),
// result = sign(d) * floor(gain*|d| / (4*r4 + |d|)) in signed Q2.14.
//
//   channel   | valid    | stall    | payload
//   ----------+----------+----------+-----------------------------------------
//   input     | i_valid  | o_stall  | i_pixel, i_local_mean, i_high_energy,
//             |          |          | i_low_energy
//   output    | o_valid  | i_stall  | o_normalized
//   gain cfg  | i_cfg_wr_en (no handshake)  | i_cfg_wr_data
//
// One request accepted per cycle while o_stall is low; each result passes
// through a pipeline depth of 63 registers: the input register, 29 stages of
// the first root, the entry register and 15 stages of the second root, one
// multiply stage, 15 divider stages and the output register. Synchronous
// active-low reset clears all valid bits and loads the gain with 1.4. A
// downstream stall first parks one result in the skid entry; o_stall then
// rises (registered) and the whole pipeline holds until the skid entry drains.
// ----------------------------------------------------------------------------
module adaptive_contrast_normalizer_unit import acn_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [PIXEL_BITS-1:0] i_pixel,
    input  logic [MEAN_W-1:0]     i_local_mean,
    input  logic [ENERGY_W-1:0]   i_high_energy,
    input  logic [ENERGY_W-1:0]   i_low_energy,
    // gain register
    input  logic                  i_cfg_wr_en,
    input  logic [GAIN_W-1:0]     i_cfg_wr_data,
    // result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [OUT_W-1:0]      o_normalized
);

    logic [GAIN_W-1:0] r_gain;

    // pipeline advance; frozen only while the skid entry holds a result
    logic              q_full;
    logic              en;

    // first root pipeline: stage 0 is the input register
    t_sq1              r_s1   [0:R1_W];
    logic              r_s1_v [0:R1_W];
    // second root pipeline
    t_sq2              r_s2   [0:R2_W];
    logic              r_s2_v [0:R2_W];
    // divider pipeline: stage 0 is the multiply register
    t_div              r_dv   [0:GAIN_W];
    logic              r_dv_v [0:GAIN_W];

    t_sq1              n_s1_0;
    t_sq2              n_s2_0;
    t_div              n_dv_0;

    logic [MAG_W-1:0]    p6;
    logic [MAG_W-1:0]    mean_x;
    logic                in_neg;
    logic [ENERGY_W-1:0] e_sel;
    logic [DEN_W-1:0]    den;
    logic [NUM_W-1:0]    num;
    logic [OUT_W-1:0]    quo_x;
    logic [OUT_W-1:0]    res;
    logic                push;

    assign en      = !q_full;
    assign o_stall = q_full;

    // ---------------------------------------------------------------- gain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_wr_en) begin
            r_gain <= i_cfg_wr_data;
        end
    end

    // ---------------------------------------------------------------- input
    // deviation sign/magnitude and side energy select; zero energy counts as 1
    always_comb begin
        p6     = MAG_W'({i_pixel, 6'b000000});
        mean_x = MAG_W'(i_local_mean);
        in_neg = p6 < mean_x;
        e_sel  = in_neg ? i_low_energy : i_high_energy;
        if (e_sel == '0) begin
            e_sel = ENERGY_W'(1);
        end
        n_s1_0.neg  = in_neg;
        n_s1_0.mag  = in_neg ? (mean_x - p6) : (p6 - mean_x);
        n_s1_0.rad  = {e_sel, 16'h0000};
        n_s1_0.rem  = '0;
        n_s1_0.root = '0;
    end

    // second root starts on the integer root of E*65536
    always_comb begin
        n_s2_0.neg  = r_s1[R1_W].neg;
        n_s2_0.mag  = r_s1[R1_W].mag;
        n_s2_0.rad  = X2_W'(r_s1[R1_W].root);
        n_s2_0.rem  = '0;
        n_s2_0.root = '0;
    end

    // denominator r6 + |d| and numerator gain*|d|; the high part of the
    // numerator is already below the denominator, so only GAIN_W steps remain
    always_comb begin
        den           = DEN_W'({r_s2[R2_W].root, 2'b00}) + DEN_W'(r_s2[R2_W].mag);
        num           = NUM_W'(r_gain) * NUM_W'(r_s2[R2_W].mag);
        n_dv_0.neg    = r_s2[R2_W].neg;
        n_dv_0.num_lo = num[GAIN_W-1:0];
        n_dv_0.den    = den;
        n_dv_0.rem    = DEN_W'(num[NUM_W-1:GAIN_W]);
        n_dv_0.quo    = '0;
    end

    // ---------------------------------------------------------------- valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= R1_W; k++) begin
                r_s1_v[k] <= 1'b0;
            end
            for (int k = 0; k <= R2_W; k++) begin
                r_s2_v[k] <= 1'b0;
            end
            for (int k = 0; k <= GAIN_W; k++) begin
                r_dv_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_s1_v[0] <= i_valid;
            for (int k = 0; k < R1_W; k++) begin
                r_s1_v[k+1] <= r_s1_v[k];
            end
            r_s2_v[0] <= r_s1_v[R1_W];
            for (int k = 0; k < R2_W; k++) begin
                r_s2_v[k+1] <= r_s2_v[k];
            end
            r_dv_v[0] <= r_s2_v[R2_W];
            for (int k = 0; k < GAIN_W; k++) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
        end
    end

    // ---------------------------------------------------------------- payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1[0] <= n_s1_0;
            for (int k = 0; k < R1_W; k++) begin
                r_s1[k+1] <= sq1_step(r_s1[k]);
            end
            r_s2[0] <= n_s2_0;
            for (int k = 0; k < R2_W; k++) begin
                r_s2[k+1] <= sq2_step(r_s2[k]);
            end
            r_dv[0] <= n_dv_0;
            for (int k = 0; k < GAIN_W; k++) begin
                r_dv[k+1] <= div_step(r_dv[k]);
            end
        end
    end

    // ---------------------------------------------------------------- output
    // apply the deviation sign; q < gain so no saturation
    assign quo_x = OUT_W'(r_dv[GAIN_W].quo);
    assign res   = r_dv[GAIN_W].neg ? (OUT_W'(0) - quo_x) : quo_x;
    assign push  = en && r_dv_v[GAIN_W];

    acn_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res),
        .o_full  (q_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_normalized)
    );

endmodule
